>>> rtl/ecal_pkg.sv
`default_nettype none

package ecal_pkg;

    // Reciprocal constants for exact division by multiplication.
    // Each is ceil(2^shift / divisor), with an error small enough for the operand range.
    localparam logic [31:0] RECIP_15       = 32'h8888_8889;   // /15, exact for 32-bit operands
    localparam int unsigned RECIP_15_SHIFT = 35;
    localparam logic [31:0] RECIP_3        = 32'hAAAA_AAAB;   // /3, exact for 32-bit operands
    localparam int unsigned RECIP_3_SHIFT  = 33;
    localparam logic [16:0] RECIP_7        = 17'd74899;       // /7, exact for 16-bit operands
    localparam int unsigned RECIP_7_SHIFT  = 19;
    localparam logic [16:0] RECIP_QUAD     = 17'd91868;       // /1461, exact for 16-bit operands
    localparam int unsigned RECIP_QUAD_SHIFT = 27;

    localparam logic [15:0] DAYS_1900_TO_1970 = 16'd25568;    // 70*365 + 18
    localparam logic [15:0] DAYS_PER_QUAD     = 16'd1461;     // 365*4 + 1
    localparam logic [10:0] YEAR1_START       = 11'd366;
    localparam logic [10:0] YEAR2_START       = 11'd731;
    localparam logic [10:0] YEAR3_START       = 11'd1096;
    localparam logic [8:0]  DAYS_TO_MARCH     = 9'd59;        // 31 + 28
    localparam int unsigned MONTHS            = 12;

    // Stages owned by the date unit.
    localparam int unsigned DATE_STAGES = 4;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [8:0] day_of_year;
        logic [7:0] years_since_1900;
        logic [2:0] weekday;
    } ecal_date_t;

    // First day of each month, counted as in a leap year.
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] s;
        unique case (m)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd60;
            4'd3:    s = 9'd91;
            4'd4:    s = 9'd121;
            4'd5:    s = 9'd152;
            4'd6:    s = 9'd182;
            4'd7:    s = 9'd213;
            4'd8:    s = 9'd244;
            4'd9:    s = 9'd274;
            4'd10:   s = 9'd305;
            4'd11:   s = 9'd335;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ecal_date.sv
`default_nettype none

module ecal_date
    import ecal_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic [DATE_STAGES-1:0] adv,
    input  wire logic [15:0]            days,
    output ecal_date_t                  date
);

    // Stage A: reciprocal products for the weekday and the four-year group.
    logic [15:0] days_a_reg;
    logic [32:0] p7_a_reg;
    logic [32:0] pq_a_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            days_a_reg <= days;
            p7_a_reg   <= 33'(days) * 33'(RECIP_7);
            pq_a_reg   <= 33'(days) * 33'(RECIP_QUAD);
        end
    end

    // Stage B: weekday and day within the four-year group.
    logic [13:0] week_q;
    logic [5:0]  quad_q;
    logic [2:0]  weekday_b_next, weekday_b_reg;
    logic [10:0] dq_b_next, dq_b_reg;
    logic [5:0]  quad_b_reg;

    always_comb
    begin
        week_q         = p7_a_reg[RECIP_7_SHIFT +: 14];
        quad_q         = pq_a_reg[RECIP_QUAD_SHIFT +: 6];
        weekday_b_next = 3'(days_a_reg - 16'(week_q) * 16'd7);
        dq_b_next      = 11'(days_a_reg - 16'(quad_q) * DAYS_PER_QUAD);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            weekday_b_reg <= weekday_b_next;
            quad_b_reg    <= quad_q;
            dq_b_reg      <= dq_b_next;
        end
    end

    // Stage C: year within the group, day of year, leap-day skip.
    logic [1:0]  yq;
    logic [10:0] d_full;
    logic [8:0]  doy;
    logic [8:0]  dayx_c_next;
    logic [7:0]  yr_c_reg;
    logic [8:0]  doy_c_reg;
    logic [8:0]  dayx_c_reg;
    logic [2:0]  weekday_c_reg;

    always_comb
    begin
        priority if (dq_b_reg >= YEAR3_START)
        begin
            yq     = 2'd3;
            d_full = dq_b_reg - YEAR3_START;
        end
        else if (dq_b_reg >= YEAR2_START)
        begin
            yq     = 2'd2;
            d_full = dq_b_reg - YEAR2_START;
        end
        else if (dq_b_reg >= YEAR1_START)
        begin
            yq     = 2'd1;
            d_full = dq_b_reg - YEAR1_START;
        end
        else
        begin
            yq     = 2'd0;
            d_full = dq_b_reg;
        end
        doy = d_full[8:0];
        // A common year has no February 29, so step over it.
        if (yq != 2'd0 && doy >= DAYS_TO_MARCH)
            dayx_c_next = doy + 9'd1;
        else
            dayx_c_next = doy;
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            yr_c_reg      <= {quad_b_reg, yq};
            doy_c_reg     <= doy;
            dayx_c_reg    <= dayx_c_next;
            weekday_c_reg <= weekday_b_reg;
        end
    end

    // Stage D: month by comparing against the month starts.
    logic [3:0] mon;
    logic [4:0] dom;
    ecal_date_t date_reg;

    always_comb
    begin
        mon = '0;
        for (int i = 1; i < MONTHS; i++)
        begin
            if (dayx_c_reg >= month_start(4'(i)))
                mon = mon + 4'd1;
        end
        dom = 5'(dayx_c_reg - month_start(mon) + 9'd1);
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            date_reg.month            <= mon;
            date_reg.day_of_month     <= dom;
            date_reg.day_of_year      <= doy_c_reg;
            date_reg.years_since_1900 <= yr_c_reg;
            date_reg.weekday          <= weekday_c_reg;
        end
    end

    assign date = date_reg;

endmodule

`default_nettype wire

>>> rtl/epoch_seconds_to_calendar_unit.sv
`default_nettype none

// Channel   Dir  Signals                           Payload
// -------   ---  --------------------------------  ----------------------------------------
// input     in   s_tvalid s_tready s_tdata[31:0]   epoch_seconds (signed)
// output    out  m_tvalid m_tready m_tdata[47:0]   second .. month, date_unset on m_tuser
//                m_tuser
//
// Each transfer on the input gives exactly one transfer on the output. The first four of the
// eight register stages divide by 60, 60 and 24 with reciprocal multiplies and rebase the day
// count to 1900; the last four are the date unit, so one conversion enters every cycle while
// the output is not stalled. Every stage has its own valid bit; an empty stage takes data
// even while later ones are stalled, so bubbles close up and a stall never drops or repeats
// a transfer. Reset clears only the valid bits; the datapath registers need none.

module epoch_seconds_to_calendar_unit
    import ecal_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] epoch_seconds
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [5:0] second, [11:6] minute, [16:12] hour,
                                        // [19:17] weekday, [27:20] years_since_1900,
                                        // [36:28] day_of_year, [41:37] day_of_month,
                                        // [45:42] month, [47:46] zero
    output logic             m_tuser    // [0] date_unset
);

    localparam int unsigned STAGES = 8;

    typedef struct packed {
        logic       unset;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } ecal_time_t;

    // Valid bits and per-stage advance enables. A stage may load when it is empty or
    // when the stage after it is loading as well.
    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] en;

    always_comb
    begin
        en[STAGES-1] = !v_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= s_tvalid;
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Stage 0: negative inputs saturate to zero; all-ones marks an unset date.
    // The first division by 60 is done as a divide by 4 and then by 15.
    logic [30:0] sat;
    logic [30:0] x0_reg;
    logic [60:0] p1_reg;
    logic        un0_reg;

    assign sat = s_tdata[31] ? '0 : s_tdata[30:0];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x0_reg  <= sat;
            p1_reg  <= 61'(sat[30:2]) * 61'(RECIP_15);
            un0_reg <= &s_tdata;
        end
    end

    // Stage 1: total minutes and the seconds field.
    logic [25:0] q1;
    logic [25:0] q1_reg;
    logic [55:0] p2_reg;
    logic [5:0]  sec1_reg;
    logic        un1_reg;

    assign q1 = p1_reg[RECIP_15_SHIFT +: 26];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            q1_reg   <= q1;
            p2_reg   <= 56'(q1[25:2]) * 56'(RECIP_15);
            sec1_reg <= 6'(x0_reg - 31'(q1) * 31'd60);
            un1_reg  <= un0_reg;
        end
    end

    // Stage 2: total hours and the minutes field. The divide by 24 is a divide by 8
    // and then by 3.
    logic [19:0] q2;
    logic [19:0] q2_reg;
    logic [48:0] p3_reg;
    logic [5:0]  sec2_reg;
    logic [5:0]  min2_reg;
    logic        un2_reg;

    assign q2 = p2_reg[RECIP_15_SHIFT +: 20];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            q2_reg   <= q2;
            p3_reg   <= 49'(q2[19:3]) * 49'(RECIP_3);
            sec2_reg <= sec1_reg;
            min2_reg <= 6'(q1_reg - 26'(q2) * 26'd60);
            un2_reg  <= un1_reg;
        end
    end

    // Stage 3: whole days, rebased to 1900, and the hours field.
    logic [15:0] d0;
    logic [15:0] days_reg;
    ecal_time_t  tm3_reg;

    assign d0 = p3_reg[RECIP_3_SHIFT +: 16];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            days_reg       <= d0 + DAYS_1900_TO_1970;
            tm3_reg.second <= sec2_reg;
            tm3_reg.minute <= min2_reg;
            tm3_reg.hour   <= 5'(q2_reg - 20'(d0) * 20'd24);
            tm3_reg.unset  <= un2_reg;
        end
    end

    // Stages 4 to 7: the date unit, with the time of day carried alongside.
    ecal_date_t date;
    ecal_time_t tm_reg [DATE_STAGES];

    ecal_date u_date (
        .clk  (clk),
        .adv  (en[STAGES-1 -: DATE_STAGES]),
        .days (days_reg),
        .date (date)
    );

    always_ff @(posedge clk)
    begin
        if (en[STAGES-DATE_STAGES])
            tm_reg[0] <= tm3_reg;
        for (int k = 1; k < DATE_STAGES; k++)
        begin
            if (en[STAGES-DATE_STAGES+k])
                tm_reg[k] <= tm_reg[k-1];
        end
    end

    // An unset date reads as all zeros with day of month 1.
    ecal_time_t tm_out;

    assign tm_out = tm_reg[DATE_STAGES-1];

    always_comb
    begin
        if (tm_out.unset)
        begin
            m_tdata        = '0;
            m_tdata[41:37] = 5'd1;
        end
        else
            m_tdata = {2'b00, date.month, date.day_of_month, date.day_of_year,
                       date.years_since_1900, date.weekday, tm_out.hour,
                       tm_out.minute, tm_out.second};
        m_tuser = tm_out.unset;
    end

endmodule

`default_nettype wire

>>> rtl/ecal_checker.sv
`default_nettype none

module ecal_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tuser
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output transfer changed while stalled");

    // An unset date shows only day of month 1.
    a_unset_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == (48'd1 << 37))
        else $error("unset date carries wrong fields");

    // Time of day stays within its ranges.
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[5:0] < 6'd60 && m_tdata[11:6] < 6'd60 && m_tdata[16:12] < 5'd24)
        else $error("time of day out of range");

    // Calendar fields stay within their ranges.
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[19:17] < 3'd7 && m_tdata[36:28] < 9'd366
            && m_tdata[41:37] != 5'd0 && m_tdata[45:42] < 4'd12
            && m_tdata[47:46] == 2'b00)
        else $error("calendar field out of range");

endmodule

bind epoch_seconds_to_calendar_unit ecal_checker u_ecal_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> verif/tb_epoch_seconds_to_calendar_unit.sv
`default_nettype none

// Testbench for the epoch-seconds to calendar converter.
//
// A clocked driver offers timestamps from a queue that the stimulus block fills at time zero.
// A clocked monitor turns every input transfer into an expected calendar result. It compares
// every output transfer, field by field, against the oldest result still outstanding. The
// block keeps no state from one conversion to the next, so the run is one long stream. It starts with
// directed corner cases and goes on with random timestamps that lean toward day, month and
// year boundaries. Both sides insert random gaps. Once, the receiver holds off long enough
// for the pipeline to fill and stall its input.

module tb_epoch_seconds_to_calendar_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS   = 1250;
    localparam int unsigned DRAIN_CYCLES   = 24;      // wait after the last result, for any stray ones
    localparam int unsigned HOLD_CYCLES    = 120;     // long receiver hold-off
    localparam int unsigned HOLD_AFTER     = 300;     // results seen before the hold-off
    localparam int unsigned MAX_REPORTS    = 40;      // printed mismatch lines
    localparam int unsigned SECS_PER_DAY   = 86400;
    localparam int unsigned LAST_FULL_DAY  = 24854;   // last day that fits whole in 31 bits

    // Predictor constants: days are counted from 1900, with one extra leap day so that
    // 1900 behaves like every other year divisible by four.
    localparam int unsigned EPOCH_DAYS     = 70 * 365 + 18;
    localparam int unsigned QUAD_DAYS      = 365 * 4 + 1;
    localparam int unsigned LEAP_YEAR_DAYS = 366;
    localparam int unsigned MARCH_FIRST    = 31 + 28;

    typedef struct {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [7:0] years_since_1900;
        logic [8:0] day_of_year;
        logic [4:0] day_of_month;
        logic [3:0] month;
        logic       date_unset;
    } calendar_t;

    typedef struct {
        logic [31:0] stamp;
        calendar_t   cal;
    } dated_stamp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // [31:0] epoch_seconds
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // [5:0] second, [11:6] minute, [16:12] hour,
                                    // [19:17] weekday, [27:20] years_since_1900,
                                    // [36:28] day_of_year, [41:37] day_of_month,
                                    // [45:42] month, [47:46] zero
    logic        m_tuser;           // [0] date_unset

    // Set with nonblocking assignments, so the driver and the receiver see it cleanly.
    logic        hold_off = 1'b0;

    logic [31:0]  stamps_to_send[$];
    dated_stamp_t calendars_due[$];

    int unsigned mismatches      = 0;
    int unsigned results_seen    = 0;
    int unsigned stamps_accepted = 0;
    int unsigned unset_stamps    = 0;
    int unsigned negative_stamps = 0;
    int unsigned input_stalls    = 0;

    epoch_seconds_to_calendar_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // Calendar predictor. Negative stamps other than the unset marker saturate to the epoch.
    function automatic calendar_t to_calendar(input logic [31:0] stamp);
        calendar_t   c;
        int unsigned t;
        int unsigned days;
        int unsigned yr;
        int unsigned d;
        int unsigned mon;
        int unsigned month_len[12] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (stamp == 32'hFFFF_FFFF) begin
            c = '{default: '0};
            c.day_of_month = 5'd1;
            c.date_unset   = 1'b1;
            return c;
        end
        t = stamp[31] ? 0 : stamp;
        c.second = 6'(t % 60);
        t = t / 60;
        c.minute = 6'(t % 60);
        t = t / 60;
        c.hour = 5'(t % 24);
        days = t / 24 + EPOCH_DAYS;
        c.weekday = 3'(days % 7);
        yr = 4 * (days / QUAD_DAYS);
        d  = days % QUAD_DAYS;
        // Only the first year of each group of four has the extra day.
        if (d >= LEAP_YEAR_DAYS) begin
            yr = yr + (d - 1) / 365;
            d  = (d - 1) % 365;
        end
        c.years_since_1900 = 8'(yr);
        c.day_of_year      = 9'(d);
        // A common year skips the 29th of February in the leap-year month table.
        if ((yr % 4) != 0 && d >= MARCH_FIRST)
            d = d + 1;
        mon = 0;
        while (mon < 11 && d >= month_len[mon]) begin
            d   = d - month_len[mon];
            mon = mon + 1;
        end
        c.day_of_month = 5'(d + 1);
        c.month        = 4'(mon);
        c.date_unset   = 1'b0;
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want, input logic [31:0] stamp);
        if (got !== want)
            report_mismatch($sformatf("stamp %08h %s got %0d expected %0d",
                                      stamp, name, got, want));
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 25);
    endfunction

    // Driver. A stamp stays on the bus until it is accepted; between transfers it inserts
    // random gaps, except during quiet stretches and while the receiver is held off.
    int unsigned send_gap  = 0;
    int unsigned calm_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            if (send_gap > 0 && !hold_off)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (stamps_to_send.size() > 0)
            begin
                s_tdata  <= stamps_to_send.pop_front();
                s_tvalid <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 19) == 0)
                    calm_left = $urandom_range(20, 60);
                send_gap = (calm_left > 0) ? 0 : pick_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver. Ready drops at random for short and occasionally long stretches.
    int unsigned stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_off)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 72)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
    end

    // Monitor. Input transfers are predicted; output transfers are checked in order.
    always @(posedge clk)
    begin : monitor
        dated_stamp_t due;
        calendar_t    got;
        if (rst_n)
        begin
            if (s_tvalid && !s_tready)
                input_stalls++;
            if (s_tvalid && s_tready)
            begin
                due.stamp = s_tdata;
                due.cal   = to_calendar(s_tdata);
                calendars_due.push_back(due);
                stamps_accepted++;
                if (s_tdata == 32'hFFFF_FFFF)
                    unset_stamps++;
                else if (s_tdata[31])
                    negative_stamps++;
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (calendars_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %012h user %0b",
                                              m_tdata, m_tuser));
                end
                else
                begin
                    due = calendars_due.pop_front();
                    got.second           = m_tdata[5:0];
                    got.minute           = m_tdata[11:6];
                    got.hour             = m_tdata[16:12];
                    got.weekday          = m_tdata[19:17];
                    got.years_since_1900 = m_tdata[27:20];
                    got.day_of_year      = m_tdata[36:28];
                    got.day_of_month     = m_tdata[41:37];
                    got.month            = m_tdata[45:42];
                    got.date_unset       = m_tuser;
                    compare_field("second", got.second, due.cal.second, due.stamp);
                    compare_field("minute", got.minute, due.cal.minute, due.stamp);
                    compare_field("hour", got.hour, due.cal.hour, due.stamp);
                    compare_field("weekday", got.weekday, due.cal.weekday, due.stamp);
                    compare_field("years_since_1900", got.years_since_1900,
                                  due.cal.years_since_1900, due.stamp);
                    compare_field("day_of_year", got.day_of_year, due.cal.day_of_year,
                                  due.stamp);
                    compare_field("day_of_month", got.day_of_month, due.cal.day_of_month,
                                  due.stamp);
                    compare_field("month", got.month, due.cal.month, due.stamp);
                    compare_field("date_unset", got.date_unset, due.cal.date_unset,
                                  due.stamp);
                end
            end
        end
    end

    // Long hold-off on the output while the driver keeps offering stamps back to back, so
    // the pipeline fills up and has to drop s_tready.
    initial
    begin
        wait (results_seen >= HOLD_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d stamps unsent and %0d results outstanding",
                 stamps_to_send.size(), calendars_due.size());
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus and end of test.
    initial
    begin
        logic [31:0] directed[] = '{
            32'h0000_0000,    // the epoch itself
            32'h0000_0001,
            32'hFFFF_FFFF,    // unset date
            32'hFFFF_FFFE,    // other negative values saturate to the epoch
            32'h8000_0000,
            32'h7FFF_FFFF,    // last representable second, 2038-01-19
            32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
            32'd31449600,     // last day of a common year
            32'd63071999,     // end of 1971
            32'd68169600,     // 29 February 1972
            32'd68255999,     // last second of 29 February 1972
            32'd946684799,    // end of 1999
            32'd946684800,    // start of 2000
            32'd951782400,    // 29 February 2000
            32'd951868800,    // 1 March 2000
            32'd978220800,    // last day of the leap year 2000
            32'd983404800,    // 1 March 2001
            32'd1234567890
        };
        int unsigned r;
        int unsigned y;
        int unsigned extra_day;
        longint      secs;

        foreach (directed[i])
            stamps_to_send.push_back(directed[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                stamps_to_send.push_back(32'hFFFF_FFFF);
            end
            else if (r < 16)
            begin
                stamps_to_send.push_back($urandom | 32'h8000_0000);
            end
            else if (r < 40)
            begin
                stamps_to_send.push_back($urandom & 32'h7FFF_FFFF);
            end
            else if (r < 70)
            begin
                // Random day, at its first, its last or a random second.
                secs = longint'($urandom_range(0, LAST_FULL_DAY)) * SECS_PER_DAY;
                case ($urandom_range(0, 3))
                    0:       secs = secs;
                    1:       secs = secs + SECS_PER_DAY - 1;
                    2:       secs = secs + 1;
                    default: secs = secs + $urandom_range(0, SECS_PER_DAY - 1);
                endcase
                stamps_to_send.push_back(secs[31:0]);
            end
            else
            begin
                // Around the start of a year or the end of February.
                y = $urandom_range(1971, 2037);
                case ($urandom_range(0, 4))
                    0:       extra_day = 0;
                    1:       extra_day = 58;
                    2:       extra_day = 59;
                    3:       extra_day = 60;
                    default: extra_day = $urandom_range(0, 365);
                endcase
                secs = (longint'(365 * (y - 1970) + (y - 1969) / 4) + extra_day)
                       * SECS_PER_DAY;
                if ($urandom_range(0, 1) == 1)
                    secs = secs - 1;
                stamps_to_send.push_back(secs[31:0]);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Sampled on the falling edge, where every driven value has settled.
        do
            @(negedge clk);
        while (stamps_to_send.size() > 0 || s_tvalid || calendars_due.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (calendars_due.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", calendars_due.size()));

        $display("Converted %0d timestamps (%0d unset, %0d other negative), %0d results checked.",
                 stamps_accepted, unset_stamps, negative_stamps, results_seen);
        $display("Input stalled for %0d cycles under output back-pressure, %0d mismatches.",
                 input_stalls, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/ecal_pkg.sv
rtl/ecal_date.sv
rtl/epoch_seconds_to_calendar_unit.sv
rtl/ecal_checker.sv
verif/tb_epoch_seconds_to_calendar_unit.sv
